FILE: sv/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the stream pattern replace block.
// ----------------------------------------------------------------------------
package spr_pkg;

    // field widths
    localparam int DATA_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // default capacity of pattern and replacement
    localparam int DEF_MAX_PATTERN_BYTES = 8;
    localparam int DEF_MAX_REPLACE_BYTES = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // one input request
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              stream_end;
    } in_item_t;

    // one result
    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              run_last;
        logic              output_end;
        logic              any_replaced;
    } out_item_t;

endpackage

FILE: sv/stream_pattern_replace.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Streaming find and replace of a configured byte pattern.
// ----------------------------------------------------------------------------
// Bytes enter one request at a time and leave rewritten: every leftmost,
// non-overlapping occurrence of the pattern is replaced, other bytes pass in
// order, and the request marked stream_end flushes the pending bytes and ends
// the stream. Timing: after a request is accepted, in_stall stays high while
// the request is evaluated and its result bytes are moved out, and longer
// while out_stall is high, so no new request is taken before the last one is
// through. The stall is set by the single prefix comparator, used once per
// cycle, and by the one result byte moved per cycle, while out_stall allows,
// through a holding register into the output register.
// ----------------------------------------------------------------------------
module stream_pattern_replace
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int MAX_REPLACE_BYTES = DEF_MAX_REPLACE_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item
);

    localparam int WIN_W     = MAX_PATTERN_BYTES * 8;
    localparam int REP_W     = MAX_REPLACE_BYTES * 8;
    localparam int REP_IDX_W = (MAX_REPLACE_BYTES > 1) ? $clog2(MAX_REPLACE_BYTES) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_REPL = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [WIN_W-1:0] pattern;
    logic [LEN_W-1:0] pattern_len;
    logic [REP_W-1:0] replace;
    logic [LEN_W-1:0] replace_len;
    logic             match;

    logic [2:0]           state_reg, state_next;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [LEN_W-1:0]     count_reg, count_next;
    logic                 last_reg, last_next;
    logic                 replaced_reg, replaced_next;
    logic [REP_IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [DATA_W-1:0]    hold_byte_reg, hold_byte_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic [WIN_W-1:0] appended;
    logic             out_free;
    logic             emit_ok;
    logic             release_needed;

    // configuration registers
    spr_cfg_regs #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pattern     (pattern),
        .pattern_len (pattern_len),
        .replace     (replace),
        .replace_len (replace_len)
    );

    // shared prefix comparator, always over the current window fill
    spr_prefix_cmp #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_cmp (
        .window  (window_reg),
        .pattern (pattern),
        .len     (count_reg),
        .match   (match)
    );

    // window with the incoming byte placed after the pending bytes
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            if (LEN_W'(i) < count_reg)
                appended[i*8 +: 8] = window_reg[i*8 +: 8];
            else if (LEN_W'(i) == count_reg)
                appended[i*8 +: 8] = in_item.data_byte;
            else
                appended[i*8 +: 8] = '0;
        end
    end

    assign out_free       = !out_valid_reg || !out_stall;
    assign emit_ok        = !hold_valid_reg || out_free;
    assign release_needed = (count_reg != '0) &&
                            (last_reg || !((count_reg < pattern_len) && match));

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        replaced_next   = replaced_reg;
        rep_idx_next    = rep_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    window_next = appended;
                    count_next  = count_reg + LEN_W'(1);
                    last_next   = in_item.stream_end;
                    state_next  = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if ((count_reg == pattern_len) && match)
                begin
                    replaced_next = 1'b1;
                    rep_idx_next  = '0;
                    state_next    = ST_REPL;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_REPL:
            begin
                if (emit_ok)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = '{hold_byte_reg, 1'b0, 1'b0, replaced_reg};
                    end
                    hold_valid_next = 1'b1;
                    hold_byte_next  = replace[rep_idx_reg*8 +: 8];
                    if (LEN_W'(rep_idx_reg) == replace_len - LEN_W'(1))
                    begin
                        window_next = '0;
                        count_next  = '0;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        rep_idx_next = rep_idx_reg + REP_IDX_W'(1);
                    end
                end
            end

            ST_SCAN:
            begin
                if (release_needed)
                begin
                    if (emit_ok)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '{hold_byte_reg, 1'b0, 1'b0, replaced_reg};
                        end
                        hold_valid_next = 1'b1;
                        hold_byte_next  = window_reg[7:0];
                        window_next     = window_reg >> 8;
                        count_next      = count_reg - LEN_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // final byte of this request carries the end marks
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_item_next   = '{hold_byte_reg, 1'b1, last_reg, replaced_reg};
                        hold_valid_next = 1'b0;
                    end
                    if (last_reg)
                    begin
                        replaced_next = 1'b0;
                        window_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            window_reg     <= '0;
            last_reg       <= 1'b0;
            replaced_reg   <= 1'b0;
            rep_idx_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            window_reg     <= window_next;
            last_reg       <= last_next;
            replaced_reg   <= replaced_next;
            rep_idx_reg    <= rep_idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        out_item_reg  <= out_item_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: sv/spr_cfg_regs.sv
// ----------------------------------------------------------------------------
// spr_cfg_regs
// Configuration registers with length clamping to the supported range.
// ----------------------------------------------------------------------------
module spr_cfg_regs
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int MAX_REPLACE_BYTES = DEF_MAX_REPLACE_BYTES
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    output logic [MAX_PATTERN_BYTES*8-1:0] pattern,
    output logic [LEN_W-1:0]               pattern_len,
    output logic [MAX_REPLACE_BYTES*8-1:0] replace,
    output logic [LEN_W-1:0]               replace_len
);

    localparam logic [LEN_W-1:0] PLEN_MAX = LEN_W'(MAX_PATTERN_BYTES);
    localparam logic [LEN_W-1:0] RLEN_MAX = LEN_W'(MAX_REPLACE_BYTES);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

    logic [MAX_PATTERN_BYTES*8-1:0] pattern_reg;
    logic [LEN_W-1:0]               pattern_len_reg;
    logic [MAX_REPLACE_BYTES*8-1:0] replace_reg;
    logic [LEN_W-1:0]               replace_len_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            pattern_len_reg <= LEN_ONE;
            replace_reg     <= '0;
            replace_len_reg <= LEN_ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:
                    pattern_reg <= cfg_data[MAX_PATTERN_BYTES*8-1:0];
                REG_PATTERN_LENGTH:
                    pattern_len_reg <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:
                    replace_reg <= cfg_data[MAX_REPLACE_BYTES*8-1:0];
                REG_REPLACEMENT_LENGTH:
                    replace_len_reg <= cfg_data[LEN_W-1:0];
                default:
                    pattern_reg <= pattern_reg;
            endcase
        end
    end

    // zero counts as one, above capacity counts as capacity
    always_comb
    begin
        if (pattern_len_reg == '0)
            pattern_len = LEN_ONE;
        else if (pattern_len_reg > PLEN_MAX)
            pattern_len = PLEN_MAX;
        else
            pattern_len = pattern_len_reg;

        if (replace_len_reg == '0)
            replace_len = LEN_ONE;
        else if (replace_len_reg > RLEN_MAX)
            replace_len = RLEN_MAX;
        else
            replace_len = replace_len_reg;
    end

    assign pattern = pattern_reg;
    assign replace = replace_reg;

endmodule

FILE: sv/spr_prefix_cmp.sv
// ----------------------------------------------------------------------------
// spr_prefix_cmp
// Compares the first len bytes of the window against the pattern.
// ----------------------------------------------------------------------------
module spr_prefix_cmp
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES
)
(
    input  logic [MAX_PATTERN_BYTES*8-1:0] window,
    input  logic [MAX_PATTERN_BYTES*8-1:0] pattern,
    input  logic [LEN_W-1:0]               len,
    output logic                           match
);

    logic [MAX_PATTERN_BYTES-1:0] byte_ok;

    // each byte below len must agree, bytes beyond len are ignored
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            byte_ok[i] = (LEN_W'(i) >= len) ||
                         (window[i*8 +: 8] == pattern[i*8 +: 8]);
        end
    end

    assign match = &byte_ok;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming find and replace block.
// ----------------------------------------------------------------------------
// Byte requests go in through the valid/stall port and every accepted request
// is run through a local copy of the rewrite rules. The expected result bytes
// queue up and are compared field by field as the block delivers them.
// Directed tests cover reset defaults, the overlap repair after a mismatch,
// clamped lengths and pattern changes in the middle of a stream. Random
// phases follow, built mostly from pattern fragments, with random gaps on the
// input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;

    // block ports
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    in_item_t              in_item     = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    out_item_t             out_item;

    // copy of the configuration registers
    logic [63:0]           pattern_reg         = '0;
    logic [LEN_W-1:0]      pattern_len_reg     = 4'd1;
    logic [63:0]           replacement_reg     = '0;
    logic [LEN_W-1:0]      replacement_len_reg = 4'd1;

    // copy of the match state
    logic [63:0]           match_window  = '0;
    int unsigned           match_count   = 0;
    bit                    replace_seen  = 1'b0;

    // bytes of the rewritten stream still to come out of the block
    out_item_t             rewritten_bytes[$];

    // stimulus controls and counters
    bit                    gaps_on       = 1'b0;
    bit                    stall_on      = 1'b0;
    int                    stall_left    = 0;
    int unsigned           cycle_count   = 0;
    int unsigned           fail_count    = 0;
    int unsigned           sent_count    = 0;
    int unsigned           stream_count  = 0;
    int unsigned           result_count  = 0;
    int unsigned           config_count  = 0;

    stream_pattern_replace dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // output stall bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [63:0] byte_mask(input int unsigned n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic int unsigned clamp_len(input logic [LEN_W-1:0] v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    // pop the oldest pending byte as a result
    function automatic out_item_t release_front();
        out_item_t r;
        r            = '0;
        r.out_byte   = match_window[7:0];
        match_window = match_window >> 8;
        match_count  = match_count - 1;
        return r;
    endfunction

    // apply one request to the local state and queue the bytes it releases
    function automatic void rewrite_step(input in_item_t req);
        int unsigned plen;
        int unsigned rlen;
        out_item_t   step_q[$];
        out_item_t   r;
        plen = clamp_len(pattern_len_reg, DEF_MAX_PATTERN_BYTES);
        rlen = clamp_len(replacement_len_reg, DEF_MAX_REPLACE_BYTES);

        // append the new byte behind the pending ones
        if (match_count > 7)
            match_count = 7;
        match_window = (match_window & byte_mask(match_count))
                       | (64'(req.data_byte) << (8 * match_count));
        match_count  = match_count + 1;

        if (match_count == plen && ((match_window ^ pattern_reg) & byte_mask(plen)) == 0)
        begin
            // whole pattern seen: emit the replacement
            replace_seen = 1'b1;
            for (int i = 0; i < rlen; i++)
            begin
                r          = '0;
                r.out_byte = replacement_reg[8*i +: 8];
                step_q.push_back(r);
            end
            match_window = '0;
            match_count  = 0;
        end
        else
        begin
            // drop bytes from the front until the rest is a proper prefix again
            while (match_count > 0 &&
                   !(match_count < plen &&
                     ((match_window ^ pattern_reg) & byte_mask(match_count)) == 0))
                step_q.push_back(release_front());
        end

        // flush at the end of the stream
        if (req.stream_end)
        begin
            while (match_count > 0)
                step_q.push_back(release_front());
            match_window = '0;
        end

        if (step_q.size() > 0)
        begin
            step_q[step_q.size()-1].run_last = 1'b1;
            if (req.stream_end)
                step_q[step_q.size()-1].output_end = 1'b1;
        end
        foreach (step_q[k])
        begin
            step_q[k].any_replaced = replace_seen;
            rewritten_bytes.push_back(step_q[k]);
        end
        if (req.stream_end)
            replace_seen = 1'b0;
    endfunction

    // compare one delivered byte with the oldest expected one
    function automatic void check_result(input out_item_t got);
        out_item_t want;
        if (rewritten_bytes.size() == 0)
        begin
            $error("unexpected result: out_byte %02h", got.out_byte);
            fail_count++;
            return;
        end
        want = rewritten_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte mismatch: expected %02h, got %02h", want.out_byte, got.out_byte);
            fail_count++;
        end
        if (got.run_last !== want.run_last)
        begin
            $error("run_last mismatch: expected %0b, got %0b", want.run_last, got.run_last);
            fail_count++;
        end
        if (got.output_end !== want.output_end)
        begin
            $error("output_end mismatch: expected %0b, got %0b", want.output_end,
                   got.output_end);
            fail_count++;
        end
        if (got.any_replaced !== want.any_replaced)
        begin
            $error("any_replaced mismatch: expected %0b, got %0b", want.any_replaced,
                   got.any_replaced);
            fail_count++;
        end
    endfunction

    // watch register writes, accepted requests and delivered results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PATTERN_BYTES:      pattern_reg         = cfg_data;
                    REG_PATTERN_LENGTH:     pattern_len_reg     = cfg_data[LEN_W-1:0];
                    REG_REPLACEMENT_BYTES:  replacement_reg     = cfg_data;
                    REG_REPLACEMENT_LENGTH: replacement_len_reg = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                rewrite_step(in_item);
            if (out_valid && !out_stall)
            begin
                check_result(out_item);
                result_count++;
            end
        end
    end

    // send one byte request, with an optional gap in front of it
    task automatic send_byte(input logic [7:0] b, input logic e);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data_byte: b, stream_end: e};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        if (e)
            stream_count++;
    endtask

    // stop sending and wait until every expected byte has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rewritten_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers on consecutive cycles
    task automatic set_config(input logic [63:0] pat, input logic [LEN_W-1:0] plen,
                              input logic [63:0] rep, input logic [LEN_W-1:0] rlen);
        cfg_write <= 1'b1;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_data  <= pat;
        @(posedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= 64'(plen);
        @(posedge clk);
        cfg_index <= REG_REPLACEMENT_BYTES;
        cfg_data  <= rep;
        @(posedge clk);
        cfg_index <= REG_REPLACEMENT_LENGTH;
        cfg_data  <= 64'(rlen);
        @(posedge clk);
        cfg_write <= 1'b0;
        config_count++;
    endtask

    // reset configuration: a zero byte is replaced by a zero byte
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        settle();
    endtask

    // mismatch inside a repeated prefix must re-check the breaking byte
    task automatic test_overlap_repair();
        set_config(64'h62_61_61, 4'd3, 64'h59_58, 4'd2);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("a", 1'b0);
        send_byte("c", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b1);
        settle();
    endtask

    // lengths of zero and above the maximum are clamped
    task automatic test_length_extremes();
        set_config('1, 4'd15, 64'h0, 4'd0);
        for (int i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);
        settle();
        set_config(64'h0, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd8);
        send_byte(8'h00, 1'b1);
        settle();
    endtask

    // new pattern written while bytes are still pending
    task automatic test_pattern_change();
        set_config(64'h63_62_61, 4'd3, 64'h21, 4'd1);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        settle();
        set_config(64'h7A_62_61, 4'd3, 64'h21, 4'd1);
        send_byte("z", 1'b0);
        settle();
        set_config(64'h71_79_78, 4'd3, 64'h3F, 4'd1);
        send_byte("x", 1'b0);
        send_byte("y", 1'b0);
        settle();
        set_config(64'h71_79, 4'd2, 64'h3F, 4'd1);
        send_byte("q", 1'b1);
        settle();
    endtask

    // random phases of streams built mostly from pattern fragments
    task automatic test_random_streams();
        logic [7:0]  sym[3];
        logic [7:0]  stream_q[$];
        logic [63:0] pat;
        logic [3:0]  plen_raw;
        logic [3:0]  rlen_raw;
        int unsigned plen;
        int unsigned stream_len;
        int unsigned frag;
        int          items_left;
        int          pick;
        bit          leave_open;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // per-phase alphabet and configuration
            foreach (sym[s])
                sym[s] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                pat = {$urandom, $urandom};
            else
                for (int i = 0; i < 8; i++)
                    pat[8*i +: 8] = sym[$urandom_range(0, 2)];
            plen_raw = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
            rlen_raw = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
            set_config(pat, plen_raw, {$urandom, $urandom}, rlen_raw);
            plen = clamp_len(plen_raw, DEF_MAX_PATTERN_BYTES);

            // idling pattern, none in the last phase
            gaps_on  = (phase != RANDOM_PHASES - 1) && (phase % 3 != 2);
            stall_on = (phase != RANDOM_PHASES - 1) && (phase % 4 != 3);

            items_left = PHASE_ITEMS;
            while (items_left > 0)
            begin
                // build one stream
                stream_len = $urandom_range(1, 16);
                stream_q.delete();
                while (stream_q.size() < stream_len)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                    begin
                        frag = ($urandom_range(0, 2) == 0) ? $urandom_range(1, plen) : plen;
                        for (int i = 0; i < frag; i++)
                            stream_q.push_back(pat[8*i +: 8]);
                    end
                    else if (pick < 8)
                        stream_q.push_back(sym[$urandom_range(0, 2)]);
                    else
                        stream_q.push_back(8'($urandom_range(0, 255)));
                end
                leave_open = ($urandom_range(0, 9) == 0);
                foreach (stream_q[i])
                    send_byte(stream_q[i], !leave_open && i == stream_q.size() - 1);
                items_left -= stream_q.size();
            end
            settle();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        test_overlap_repair();
        test_length_extremes();
        test_pattern_change();
        test_random_streams();

        $display("sent %0d requests in %0d closed streams, checked %0d result bytes",
                 sent_count, stream_count, result_count);
        $display("used %0d register settings, %0d mismatches", config_count, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
